// File: rtl/core/stfk_pkg.sv
// Shared types and constants for the temperature fusion Kalman unit.
package stfk_pkg;

   localparam logic [1:0] ACT_MOTION  = 2'd0;
   localparam logic [1:0] ACT_CLIMATE = 2'd1;
   localparam logic [1:0] ACT_GAS     = 2'd2;

   localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
   localparam logic [23:0] UNC_MAX   = 24'hFF_FFFF;
   localparam logic [23:0] UNC_RESET = 24'd65536;
   localparam logic [19:0] PNOISE_RESET = 20'd655;
   localparam logic [19:0] SNOISE_RESET = 20'd6554;

   localparam logic REG_PNOISE = 1'b0;
   localparam logic REG_SNOISE = 1'b1;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  msg_length;
      logic [31:0] value_bits;
   } req_type;

   typedef struct packed {
      logic signed [47:0] filtered_temp;
      logic signed [47:0] average_temp;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture item, update marks
      logic div_start; // begin gain division
      logic div_step;  // one quotient bit
      logic mul_step;  // one multiply-accumulate bit
      logic finish;    // commit estimate, uncertainty, clear marks
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic fuse;      // all three sensors present after load
   } sts_type;

   // IEEE single to Q31.16, truncation, saturating; NaN and denormals give 0
   function automatic logic signed [47:0] float_to_q16(input logic [31:0] b);
      logic [7:0]  e;
      logic [47:0] m;
      logic [47:0] mag;
      logic signed [47:0] r;
      e = b[30:23];
      m = {24'd0, 1'b1, b[22:0]};
      mag = '0;
      r = '0;
      if (e == 8'd255) begin
         if (b[22:0] != 23'd0) r = '0;
         else r = b[31] ? MIN48 : MAX48;
      end else if (e == 8'd0) begin
         r = '0;
      end else if (e >= 8'd158) begin
         r = b[31] ? MIN48 : MAX48;
      end else begin
         if (e >= 8'd134) mag = m << (e - 8'd134);
         else if (e > 8'd110) mag = m >> (8'd134 - e);
         else mag = '0;
         r = b[31] ? -$signed(mag) : $signed(mag);
      end
      return r;
   endfunction

endpackage

// File: rtl/core/stfk_ctrl.sv
// Controller state machine: sequences load, gain division and update multiply.
module stfk_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stfk_pkg::cmd_type cmd,
   input  stfk_pkg::sts_type sts
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EVAL = 5'b00010,
      S_DIV  = 5'b00100,
      S_MUL  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rv_ff, rv_in;
   logic       accept;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rv_in    = rv_ff && rsp_stall;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (sts.fuse) begin
               cmd.div_start = 1'b1;
               cnt_in   = 5'd0;
               state_in = S_DIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               cnt_in   = 5'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               rv_in      = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end

endmodule

// File: rtl/core/stfk_dp.sv
// Datapath: sensor state, serial gain divider, serial multipliers, output register.
module stfk_dp #(
   parameter int MOTION_MAX_LEN  = 20,
   parameter int CLIMATE_MAX_LEN = 12,
   parameter int GAS_MAX_LEN     = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  stfk_pkg::req_type req_data,
   input  logic [19:0]       pnoise,
   input  logic [19:0]       snoise,
   input  stfk_pkg::cmd_type cmd,
   output stfk_pkg::sts_type sts,
   output stfk_pkg::rsp_type rsp_data
);

   logic gm_ff, gc_ff, gg_ff;
   logic signed [31:0] ct_ff;
   logic signed [47:0] gt_ff;
   logic signed [47:0] est_ff, est_in;
   logic [23:0] unc_ff;
   logic signed [47:0] avg_ff;
   logic signed [48:0] diff_ff;
   // divider
   logic [24:0] den_ff;
   logic [25:0] rem_ff;
   logic [39:0] num_ff;
   logic [16:0] q_ff;
   logic [25:0] rem_sh;
   // multipliers: gain * diff and (65536-gain) * P, shift-add over gain bits
   logic signed [65:0] acc_d_ff;
   logic [40:0] acc_p_ff;
   logic [16:0] g_ff;
   logic [16:0] gi_ff;
   logic [16:0] gi_now;
   logic [4:0]  bit_ff;
   logic signed [48:0] sum49;
   logic [24:0] psat;
   stfk_pkg::rsp_type rsp_ff;

   logic ok;
   always_comb begin
      ok = 1'b0;
      case (req_data.action)
         stfk_pkg::ACT_MOTION:  ok = ({24'd0, req_data.msg_length} <= 32'(MOTION_MAX_LEN));
         stfk_pkg::ACT_CLIMATE: ok = ({24'd0, req_data.msg_length} <= 32'(CLIMATE_MAX_LEN));
         stfk_pkg::ACT_GAS:     ok = ({24'd0, req_data.msg_length} <= 32'(GAS_MAX_LEN));
         default:               ok = 1'b0;
      endcase
   end

   assign sts.fuse = gm_ff && gc_ff && gg_ff;
   assign sum49 = {{1{ct_ff[31]}}, ct_ff, 16'd0} + {gt_ff[47], gt_ff};
   assign rem_sh = {rem_ff[24:0], num_ff[39]};
   assign gi_now = 17'd65536 - q_ff;
   // floor(g*diff/65536) == hi*g + floor(lo*g/65536) exactly
   assign est_in = est_ff + 48'(acc_d_ff >>> 16);
   always_comb begin
      psat = {1'b0, acc_p_ff[39:16]} + {5'd0, pnoise};
      if (acc_p_ff[40] || psat[24]) psat = {1'b0, stfk_pkg::UNC_MAX};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gm_ff  <= 1'b0;
         gc_ff  <= 1'b0;
         gg_ff  <= 1'b0;
         ct_ff  <= '0;
         gt_ff  <= '0;
         est_ff <= '0;
         unc_ff <= stfk_pkg::UNC_RESET;
      end else begin
         if (cmd.load && ok) begin
            case (req_data.action)
               stfk_pkg::ACT_MOTION:  gm_ff <= 1'b1;
               stfk_pkg::ACT_CLIMATE: begin
                  gc_ff <= 1'b1;
                  ct_ff <= $signed(req_data.value_bits);
               end
               stfk_pkg::ACT_GAS: begin
                  gg_ff <= 1'b1;
                  gt_ff <= stfk_pkg::float_to_q16(req_data.value_bits);
               end
               default: ;
            endcase
         end
         if (cmd.finish) begin
            gm_ff  <= 1'b0;
            gc_ff  <= 1'b0;
            gg_ff  <= 1'b0;
            est_ff <= est_in;
            unc_ff <= psat[23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         avg_ff  <= sum49[48:1];
         diff_ff <= {sum49[48], sum49[48:1]} - {est_ff[47], est_ff};
         den_ff  <= {1'b0, unc_ff} + {5'd0, snoise};
         // quotient fits 17 bits, so the top 23 numerator bits start as the
         // partial remainder; the last 17 bits are shifted in one per step
         num_ff  <= {unc_ff[0], 16'd0, 23'd0};
         rem_ff  <= {3'd0, unc_ff[23:1]};
         q_ff    <= '0;
         bit_ff  <= '0;
      end
      if (cmd.div_step) begin
         num_ff <= num_ff << 1;
         if (den_ff != 25'd0 && rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= rem_sh - {1'b0, den_ff};
            q_ff   <= {q_ff[15:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            q_ff   <= {q_ff[15:0], 1'b0};
         end
         acc_d_ff <= '0;
         acc_p_ff <= '0;
         bit_ff   <= '0;
      end
      if (cmd.mul_step) begin
         if (bit_ff == 5'd0) begin
            g_ff  <= q_ff;
            gi_ff <= gi_now;
            acc_d_ff <= q_ff[0] ? 66'(diff_ff) : '0;
            acc_p_ff <= gi_now[0] ? 41'(unc_ff) : '0;
         end else begin
            if (g_ff[bit_ff])
               acc_d_ff <= acc_d_ff + (66'(diff_ff) <<< bit_ff);
            if (gi_ff[bit_ff])
               acc_p_ff <= acc_p_ff + (41'(unc_ff) << bit_ff);
         end
         bit_ff <= bit_ff + 5'd1;
      end
      if (cmd.finish) begin
         rsp_ff.filtered_temp <= est_in;
         rsp_ff.average_temp  <= avg_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/core/sensor_temp_fusion_kalman_unit.sv
// Top level of the temperature fusion Kalman unit.
//  channel | ports          | direction | payload
//  req     | valid / stall  | in        | stfk_pkg::req_type
//  rsp     | valid / stall  | out       | stfk_pkg::rsp_type
//  csr     | APB-style      | in/out    | Q noise @0x0, R noise @0x4
// An item that does not complete a fusion returns to idle after evaluation; a
// fusion runs 17 gain-division steps, then 17 shift-add multiply steps,
// both serial over the 17-bit gain, and then waits for the output.
// Reset is synchronous, active high; it restores marks, estimate, P and the noise registers.
// The result register holds an item while rsp_stall is high; the final
// commit waits for it to drain.
module sensor_temp_fusion_kalman_unit #(
   parameter int MOTION_MAX_LEN  = 20,
   parameter int CLIMATE_MAX_LEN = 12,
   parameter int GAS_MAX_LEN     = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stfk_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stfk_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   stfk_pkg::cmd_type cmd;
   stfk_pkg::sts_type sts;
   logic [19:0] pnoise_ff, snoise_ff;

   assign pready = 1'b1;

   // register file; index is paddr[2]
   always_ff @(posedge clock) begin
      if (reset) begin
         pnoise_ff <= stfk_pkg::PNOISE_RESET;
         snoise_ff <= stfk_pkg::SNOISE_RESET;
      end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
         if (paddr[2] == stfk_pkg::REG_PNOISE) pnoise_ff <= pwdata[19:0];
         else snoise_ff <= pwdata[19:0];
      end
   end

   assign prdata = (paddr[1:0] != 2'd0) ? 32'd0 :
                   (paddr[2] == stfk_pkg::REG_PNOISE) ? {12'd0, pnoise_ff}
                                                      : {12'd0, snoise_ff};

   stfk_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts
   );

   stfk_dp #(
      .MOTION_MAX_LEN(MOTION_MAX_LEN),
      .CLIMATE_MAX_LEN(CLIMATE_MAX_LEN),
      .GAS_MAX_LEN(GAS_MAX_LEN)
   ) u_dp (
      .clock, .reset, .req_data, .pnoise(pnoise_ff), .snoise(snoise_ff),
      .cmd, .sts, .rsp_data
   );

endmodule

// File: rtl/core/stfk_checker.sv
// Port-level checker for the fusion unit, with its bind.
module stfk_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic pready
);
   // an accepted item always blocks the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("no busy after item");
   // a new result only appears right after input was blocked
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall)) else $error("result without work");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
   a_rdy: assert property (@(posedge clock) pready) else $error("pready low");
endmodule

bind sensor_temp_fusion_kalman_unit stfk_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .pready
);
